// ----- src/tfpm_pkg.sv -----
`timescale 1ns / 1ps

package tfpm_pkg;

    // Datapath widths
    localparam int ACC_W      = 52;             // multiplier accumulator, signed
    localparam int MB_W       = 21;             // multiplier operand scanned bit by bit
    localparam int NUM_W      = 43;             // divider numerator magnitude
    localparam int DEN_W      = 16;             // divider divisor
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int QS_W       = NUM_W + 1;      // signed quotient
    localparam int P_W        = 27;             // proportional term
    localparam int INTEG_W    = 19;             // integral term, within +/- 1023*256
    localparam int SUM_W      = 46;             // unclamped PID sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed coefficients
    localparam logic [MB_W-1:0]  GYRO_STEP  = MB_W'(1342177);  // 0.08 in Q24
    localparam logic [MB_W-1:0]  COEF_OLD   = MB_W'(64225);    // 0.98 in Q0.16
    localparam logic [MB_W-1:0]  COEF_NEW   = MB_W'(1311);     // 0.02 in Q0.16
    localparam logic [MB_W-1:0]  MS_PER_S   = MB_W'(1000);
    localparam logic [DEN_W-1:0] INTEG_DEN  = DEN_W'(1000);    // 256000 after the >> 8
    localparam logic [ACC_W-1:0] RND_Q16    = ACC_W'(32768);
    localparam logic [ACC_W-1:0] RND_Q7     = ACC_W'(64);
    localparam logic [ACC_W-1:0] INTEG_BIAS = ACC_W'(128000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ILIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd6;

    // Motor direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] a;      // signed multiplicand
        logic [MB_W-1:0]  b;      // unsigned multiplier
        logic [ACC_W-1:0] init;   // accumulator start value
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] acc;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- src/tfpm_ser_mul.sv -----
`timescale 1ns / 1ps

module tfpm_ser_mul
    import tfpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [ACC_W-1:0] r_a, n_a;
    logic [MB_W-1:0]  r_b, n_b;
    logic [ACC_W-1:0] r_acc, n_acc;

    // Shift-add: one multiplier bit per cycle, stop once the remaining bits are zero
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = i_req.init;
            n_busy = (i_req.b != '0);
            n_done = (i_req.b == '0);
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a = r_a << 1;
            n_b = r_b >> 1;
            if (r_b[MB_W-1:1] == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");

    a_last_bit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_b[MB_W-1:1] == '0) |=> (r_done && !r_busy))
        else $error("multiplier missed its done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier flagged done while still busy");
`endif

endmodule

// ----- src/tfpm_ser_div.sv -----
`timescale 1ns / 1ps

module tfpm_ser_div
    import tfpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]     r_q, n_q;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // Restoring division: one quotient bit per cycle, numerator shifts out MSB first
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_STEPS;
            n_q    = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_q   = {r_q[NUM_W-2:0], fits};
            n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

`ifndef NO_ASSERTIONS
    a_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (i_req.den != '0 && !r_busy))
        else $error("divider started with zero divisor or while busy");

    a_count_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_busy && r_cnt == DIV_STEPS))
        else $error("divider did not load its step count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flagged done while still busy");
`endif

endmodule

// ----- src/tilt_filter_pid_motor_drive.sv -----
// Tilt filter with PID motor drive. Each item (accelerometer angle, gyro rate, elapsed
// milliseconds) updates a complementary-filter angle estimate and runs one PID step; one
// result item (direction, speed, filtered angle, saturated PID sum) comes out per input item.
// One item is processed at a time. Eight products go through one shift-add multiplier that
// consumes one multiplier bit per cycle (21, 16, 11, 16, 16, 16, 16 and 10 bits), and two
// 43-bit quotients go through one restoring divider at one bit per cycle. Zero gains finish
// their product at once, and a zero elapsed time skips the derivative path. The next item is
// taken while a finished result still waits in the output register. Configuration writes are
// accepted in every cycle and must only be issued while the block is idle.
`timescale 1ns / 1ps

module tilt_filter_pid_motor_drive
    import tfpm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [15:0]     i_accel_angle,
    input  logic signed [15:0]     i_gyro_rate,
    input  logic [15:0]            i_elapsed_ms,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_direction,
    output logic [7:0]             o_speed,
    output logic signed [15:0]     o_filtered_angle,
    output logic signed [31:0]     o_pid_output
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GYRO    = 4'd1;
    localparam logic [3:0] S_EST_OLD = 4'd2;
    localparam logic [3:0] S_EST_NEW = 4'd3;
    localparam logic [3:0] S_ANGLE   = 4'd4;
    localparam logic [3:0] S_KP      = 4'd5;
    localparam logic [3:0] S_KI      = 4'd6;
    localparam logic [3:0] S_KI_MS   = 4'd7;
    localparam logic [3:0] S_DIV_I   = 4'd8;
    localparam logic [3:0] S_KD      = 4'd9;
    localparam logic [3:0] S_KD_K    = 4'd10;
    localparam logic [3:0] S_DIV_D   = 4'd11;
    localparam logic [3:0] S_SUM     = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // configuration registers
    logic signed [15:0]        r_setpoint;
    logic [15:0]               r_kp;
    logic [15:0]               r_ki;
    logic [15:0]               r_kd;
    logic [9:0]                r_ilimit;
    logic [11:0]               r_deadband;
    logic [7:0]                r_min_speed;

    // control and loop state
    logic [3:0]                r_state, n_state;
    logic                      r_go, n_go;
    logic                      r_out_valid, n_out_valid;
    logic signed [31:0]        r_est;
    logic signed [16:0]        r_last_err;
    logic signed [INTEG_W-1:0] r_integ;

    // per-item working registers
    logic signed [15:0]        r_accel;
    logic signed [15:0]        r_gyro;
    logic [15:0]               r_ms;
    logic signed [15:0]        r_ang;
    logic signed [16:0]        r_err;
    logic signed [P_W-1:0]     r_p;
    logic                      r_dneg;
    logic signed [QS_W-1:0]    r_qi;
    logic signed [QS_W-1:0]    r_qd;
    logic signed [31:0]        r_sum;
    logic                      r_inside;

    // output registers
    logic [1:0]                r_direction;
    logic [7:0]                r_speed;
    logic signed [15:0]        r_angle_out;
    logic signed [31:0]        r_pid;

    t_mul_req                  mul_req;
    t_mul_rsp                  mul_rsp;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    logic signed [ACC_W-1:0]   acc_s;
    logic signed [ACC_W-1:0]   est_full;
    logic signed [31:0]        est_sat;
    logic signed [32:0]        ang_rnd;
    logic signed [15:0]        ang_sat;
    logic signed [16:0]        err_new;
    logic [ACC_W-1:0]          div_mag;
    logic signed [QS_W-1:0]    q_s;
    logic [17:0]               lim_u;
    logic signed [QS_W:0]      lim_s;
    logic signed [QS_W:0]      integ_w;
    logic signed [INTEG_W-1:0] integ_c;
    logic signed [SUM_W-1:0]   sum_w;
    logic signed [31:0]        sum_sat;
    logic [16:0]               err_mag;
    logic                      in_deadband;
    logic [31:0]               abs_sum;
    logic [23:0]               spd_raw;
    logic [7:0]                spd;
    logic [1:0]                dir;
    logic                      out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= 16'sd0;
            r_kp        <= 16'd17920;
            r_ki        <= 16'd384;
            r_kd        <= 16'd768;
            r_ilimit    <= 10'd60;
            r_deadband  <= 12'd192;
            r_min_speed <= 8'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SETPOINT:  r_setpoint  <= i_cfg_data;
                REG_KP:        r_kp        <= i_cfg_data;
                REG_KI:        r_ki        <= i_cfg_data;
                REG_KD:        r_kd        <= i_cfg_data;
                REG_ILIMIT:    r_ilimit    <= i_cfg_data[9:0];
                REG_DEADBAND:  r_deadband  <= i_cfg_data[11:0];
                REG_MIN_SPEED: r_min_speed <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Filter: new estimate, then rounded angle and error
    assign acc_s    = $signed(mul_rsp.acc);
    assign est_full = acc_s >>> 16;
    always_comb begin
        if (est_full > ACC_W'(S32_MAX)) begin
            est_sat = S32_MAX;
        end else if (est_full < ACC_W'(S32_MIN)) begin
            est_sat = S32_MIN;
        end else begin
            est_sat = est_full[31:0];
        end
    end

    assign ang_rnd = (33'(r_est) + 33'sd128) >>> 8;
    always_comb begin
        if (ang_rnd > 33'sd32767) begin
            ang_sat = 16'sh7FFF;
        end else if (ang_rnd < -33'sd32768) begin
            ang_sat = 16'sh8000;
        end else begin
            ang_sat = ang_rnd[15:0];
        end
    end
    assign err_new = 17'(r_setpoint) - 17'(ang_sat);

    // Select multiplier operands per step
    always_comb begin
        mul_req.start = r_go;
        unique case (r_state)
            S_GYRO: begin
                mul_req.a    = ACC_W'(r_gyro);
                mul_req.b    = GYRO_STEP;
                mul_req.init = RND_Q16;
            end
            S_EST_OLD: begin
                mul_req.a    = ACC_W'(r_est) + est_full;
                mul_req.b    = COEF_OLD;
                mul_req.init = RND_Q16;
            end
            S_EST_NEW: begin
                mul_req.a    = ACC_W'(r_accel) <<< 8;
                mul_req.b    = COEF_NEW;
                mul_req.init = mul_rsp.acc;
            end
            S_KP: begin
                mul_req.a    = ACC_W'(r_err);
                mul_req.b    = MB_W'(r_kp);
                mul_req.init = RND_Q7;
            end
            S_KI: begin
                mul_req.a    = ACC_W'(r_err);
                mul_req.b    = MB_W'(r_ki);
                mul_req.init = '0;
            end
            S_KI_MS: begin
                mul_req.a    = mul_rsp.acc << 1;
                mul_req.b    = MB_W'(r_ms);
                mul_req.init = INTEG_BIAS;
            end
            S_KD: begin
                mul_req.a    = ACC_W'(r_err) - ACC_W'(r_last_err);
                mul_req.b    = MB_W'(r_kd);
                mul_req.init = '0;
            end
            S_KD_K: begin
                mul_req.a    = mul_rsp.acc << 1;
                mul_req.b    = MS_PER_S;
                mul_req.init = ACC_W'({r_ms, 7'b0});
            end
            default: begin
                mul_req.start = 1'b0;
                mul_req.a     = '0;
                mul_req.b     = '0;
                mul_req.init  = '0;
            end
        endcase
    end

    // Floor division of a signed numerator: divide the ones complement when negative
    assign div_mag       = mul_rsp.acc[ACC_W-1] ? ~mul_rsp.acc : mul_rsp.acc;
    assign div_req.start = r_go && (r_state == S_DIV_I || r_state == S_DIV_D);
    assign div_req.num   = div_mag[NUM_W+7:8];
    assign div_req.den   = (r_state == S_DIV_I) ? INTEG_DEN : r_ms;
    assign q_s           = r_dneg ? ~{1'b0, div_rsp.quo} : {1'b0, div_rsp.quo};

    tfpm_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    tfpm_ser_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Clamp the integral and form the saturated PID sum
    assign lim_u   = {r_ilimit, 8'b0};
    assign lim_s   = $signed((QS_W + 1)'(lim_u));
    assign integ_w = (QS_W + 1)'(r_integ) + (QS_W + 1)'(r_qi);
    always_comb begin
        if (integ_w > lim_s) begin
            integ_c = INTEG_W'(lim_s);
        end else if (integ_w < -lim_s) begin
            integ_c = INTEG_W'(-lim_s);
        end else begin
            integ_c = INTEG_W'(integ_w);
        end
    end

    assign sum_w = SUM_W'(r_p) + SUM_W'(integ_c) + SUM_W'(r_qd);
    always_comb begin
        if (sum_w > SUM_W'(S32_MAX)) begin
            sum_sat = S32_MAX;
        end else if (sum_w < SUM_W'(S32_MIN)) begin
            sum_sat = S32_MIN;
        end else begin
            sum_sat = sum_w[31:0];
        end
    end

    assign err_mag     = r_err[16] ? 17'(-r_err) : r_err;
    assign in_deadband = (err_mag < 17'(r_deadband));

    // Drive decision from the registered sum
    assign abs_sum = r_sum[31] ? (32'd0 - r_sum) : r_sum;
    assign spd_raw = abs_sum[31:8];
    always_comb begin
        if (r_inside) begin
            dir = DIR_STOP;
            spd = 8'd0;
        end else begin
            dir = (!r_sum[31] && r_sum != 32'sd0) ? DIR_FWD : DIR_BACK;
            if (spd_raw < 24'(r_min_speed)) begin
                spd = r_min_speed;
            end else if (spd_raw > 24'd255) begin
                spd = 8'd255;
            end else begin
                spd = spd_raw[7:0];
            end
        end
    end

    // Sequence the steps of one item
    always_comb begin
        n_state     = r_state;
        n_go        = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_GYRO;
                    n_go    = 1'b1;
                end
            end
            S_GYRO: begin
                if (mul_rsp.done) begin
                    n_state = S_EST_OLD;
                    n_go    = 1'b1;
                end
            end
            S_EST_OLD: begin
                if (mul_rsp.done) begin
                    n_state = S_EST_NEW;
                    n_go    = 1'b1;
                end
            end
            S_EST_NEW: begin
                if (mul_rsp.done) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_state = S_KP;
                n_go    = 1'b1;
            end
            S_KP: begin
                if (mul_rsp.done) begin
                    n_state = S_KI;
                    n_go    = 1'b1;
                end
            end
            S_KI: begin
                if (mul_rsp.done) begin
                    n_state = S_KI_MS;
                    n_go    = 1'b1;
                end
            end
            S_KI_MS: begin
                if (mul_rsp.done) begin
                    n_state = S_DIV_I;
                    n_go    = 1'b1;
                end
            end
            S_DIV_I: begin
                if (div_rsp.done) begin
                    if (r_ms == '0) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_KD;
                        n_go    = 1'b1;
                    end
                end
            end
            S_KD: begin
                if (mul_rsp.done) begin
                    n_state = S_KD_K;
                    n_go    = 1'b1;
                end
            end
            S_KD_K: begin
                if (mul_rsp.done) begin
                    n_state = S_DIV_D;
                    n_go    = 1'b1;
                end
            end
            S_DIV_D: begin
                if (div_rsp.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_est       <= 32'sd0;
            r_last_err  <= 17'sd0;
            r_integ     <= '0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
            if (r_state == S_EST_NEW && mul_rsp.done) begin
                r_est <= est_sat;
            end
            if (r_state == S_SUM) begin
                r_last_err <= r_err;
                r_integ    <= in_deadband ? INTEG_W'(0) : integ_c;
            end
        end
    end

    // Hold per-item operands and partial results
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_accel <= i_accel_angle;
            r_gyro  <= i_gyro_rate;
            r_ms    <= i_elapsed_ms;
        end
        if (r_state == S_ANGLE) begin
            r_ang <= ang_sat;
            r_err <= err_new;
        end
        if (r_state == S_KP && mul_rsp.done) begin
            r_p <= P_W'(acc_s >>> 7);
        end
        if (div_req.start) begin
            r_dneg <= mul_rsp.acc[ACC_W-1];
        end
        if (r_state == S_DIV_I && div_rsp.done) begin
            r_qi <= q_s;
            if (r_ms == '0) begin
                r_qd <= '0;
            end
        end
        if (r_state == S_DIV_D && div_rsp.done) begin
            r_qd <= q_s;
        end
        if (r_state == S_SUM) begin
            r_sum    <= sum_sat;
            r_inside <= in_deadband;
        end
        if (r_state == S_OUT && out_free) begin
            r_direction <= dir;
            r_speed     <= spd;
            r_angle_out <= r_ang;
            r_pid       <= r_sum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_direction      = r_direction;
    assign o_speed          = r_speed;
    assign o_filtered_angle = r_angle_out;
    assign o_pid_output     = r_pid;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_GYRO && r_go))
        else $error("accepted item did not start the gyro step");

    a_stop_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_direction == DIR_STOP) |-> (o_speed == 8'd0))
        else $error("stopped motors report nonzero speed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_direction) &&
            $stable(o_speed) && $stable(o_filtered_angle) && $stable(o_pid_output)))
        else $error("waiting result item changed or dropped");
`endif

endmodule

// ----- tb/sv/tb_tilt_filter_pid_motor_drive.sv -----
`timescale 1ns / 1ps

module tb_tilt_filter_pid_motor_drive;
    import tfpm_pkg::*;

    localparam int     STALL_LIMIT = 5000;
    localparam int     DRAIN_WAIT  = 300;
    localparam longint GYRO_Q16    = 1342177;
    localparam longint KEEP_Q16    = 64225;
    localparam longint BLEND_Q16   = 1311;
    localparam longint I32_MIN     = -(longint'(1) <<< 31);
    localparam longint I32_MAX     = (longint'(1) <<< 31) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_SETTLE} t_op_kind;

    typedef struct {
        t_op_kind                kind;
        logic signed [15:0]      accel;
        logic signed [15:0]      gyro;
        logic [15:0]             ms;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
    } t_drive_op;

    typedef struct packed {
        logic [1:0]         direction;
        logic [7:0]         speed;
        logic signed [15:0] angle;
        logic signed [31:0] pid;
    } t_drive_result;

    // DUT connections
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [15:0]     i_accel_angle = '0;
    logic signed [15:0]     i_gyro_rate = '0;
    logic [15:0]            i_elapsed_ms = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [1:0]             o_direction;
    logic [7:0]             o_speed;
    logic signed [15:0]     o_filtered_angle;
    logic signed [31:0]     o_pid_output;

    // Stimulus plan and expected results
    t_drive_op      sample_plan[$];
    t_drive_result  expected_drive[$];
    int             n_sent = 0;
    int             n_got = 0;
    int             n_errors = 0;
    int             hold_cnt = 0;
    int             stall_cnt = 0;
    int             idle_cycles = 0;
    logic           calm_in = 1'b0;
    logic           calm_out = 1'b0;

    // Shadow registers, at their reset values
    logic signed [15:0] sh_setpoint = 16'sd0;
    logic [15:0]        sh_kp = 16'd17920;
    logic [15:0]        sh_ki = 16'd384;
    logic [15:0]        sh_kd = 16'd768;
    logic [9:0]         sh_ilimit = 10'd60;
    logic [11:0]        sh_deadband = 12'd192;
    logic [7:0]         sh_min_speed = 8'd20;

    // Filter and PID state
    int est_q8 = 0;
    int prev_err = 0;
    int integ_q8 = 0;

    tilt_filter_pid_motor_drive i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_accel_angle    (i_accel_angle),
        .i_gyro_rate      (i_gyro_rate),
        .i_elapsed_ms     (i_elapsed_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_direction      (o_direction),
        .o_speed          (o_speed),
        .o_filtered_angle (o_filtered_angle),
        .o_pid_output     (o_pid_output)
    );

    always #5 i_clk = ~i_clk;

    // Round to nearest at bit k, ties upward
    function automatic longint round_q(longint x, int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // Nearest quotient, ties upward, positive divisor
    function automatic longint div_nearest(longint n, longint d);
        longint num;
        num = 2 * n + d;
        if (num >= 0) return num / (2 * d);
        return -((-num + 2 * d - 1) / (2 * d));
    endfunction

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Advance filter and PID state by one sample and return the drive command
    function automatic t_drive_result predict_drive(logic signed [15:0] accel,
                                                    logic signed [15:0] gyro,
                                                    logic [15:0] ms);
        longint step, est, ang, err, prop, integ, lim, deriv, sum, mag, spd;
        t_drive_result res;
        // propagate by the gyro, then blend in the accelerometer
        step = round_q(longint'(gyro) * GYRO_Q16, 16);
        est = round_q(KEEP_Q16 * (longint'(est_q8) + step) +
                      BLEND_Q16 * (longint'(accel) * 256), 16);
        est = clamp_to(est, I32_MIN, I32_MAX);
        est_q8 = int'(est);
        ang = clamp_to(round_q(est, 8), -32768, 32767);
        err = longint'(sh_setpoint) - ang;

        prop = round_q(longint'(sh_kp) * err, 7);
        lim = longint'(sh_ilimit) * 256;
        integ = longint'(integ_q8) +
                div_nearest(longint'(sh_ki) * err * longint'(ms), 128000);
        integ = clamp_to(integ, -lim, lim);
        if (ms == 16'd0) begin
            deriv = 0;
        end else begin
            deriv = div_nearest(longint'(sh_kd) * (err - longint'(prev_err)) * 1000,
                                128 * longint'(ms));
        end
        sum = clamp_to(prop + integ + deriv, I32_MIN, I32_MAX);
        prev_err = int'(err);

        // stop inside the deadband, else drive by the sign of the sum
        mag = (err < 0) ? -err : err;
        if (mag < longint'(sh_deadband)) begin
            res.direction = DIR_STOP;
            spd = 0;
            integ = 0;
        end else begin
            res.direction = (sum > 0) ? DIR_FWD : DIR_BACK;
            spd = clamp_to(((sum > 0) ? sum : -sum) >>> 8, longint'(sh_min_speed), 255);
        end
        integ_q8 = int'(integ);
        res.speed = spd[7:0];
        res.angle = ang[15:0];
        res.pid = sum[31:0];
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_sample(int accel, int gyro, int ms);
        t_drive_op op;
        op.kind = OP_SAMPLE;
        op.accel = accel[15:0];
        op.gyro = gyro[15:0];
        op.ms = ms[15:0];
        op.reg_idx = '0;
        op.reg_data = '0;
        sample_plan.push_back(op);
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, int data);
        t_drive_op op;
        op.kind = OP_WRITE;
        op.accel = '0;
        op.gyro = '0;
        op.ms = '0;
        op.reg_idx = idx;
        op.reg_data = data[CFG_DATA_W-1:0];
        sample_plan.push_back(op);
    endtask

    task automatic add_settle();
        t_drive_op op;
        op.kind = OP_SETTLE;
        op.accel = '0;
        op.gyro = '0;
        op.ms = '0;
        op.reg_idx = '0;
        op.reg_data = '0;
        sample_plan.push_back(op);
    endtask

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            n_errors++;
        end
    endtask

    // Driver: feed samples and register writes from the plan
    always @(posedge i_clk) begin
        logic      in_busy;
        logic      cfg_busy;
        logic      drained;
        t_drive_op op;
        in_busy = i_in_valid;
        cfg_busy = i_cfg_valid;
        if (!i_rst_n) begin
            in_busy = 1'b0;
            cfg_busy = 1'b0;
        end else begin
            // retire accepted items
            if (i_in_valid && o_in_ready) begin
                expected_drive.push_back(predict_drive(i_accel_angle, i_gyro_rate,
                                                       i_elapsed_ms));
                n_sent <= n_sent + 1;
                in_busy = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SETPOINT:  sh_setpoint = i_cfg_data;
                    REG_KP:        sh_kp = i_cfg_data;
                    REG_KI:        sh_ki = i_cfg_data;
                    REG_KD:        sh_kd = i_cfg_data;
                    REG_ILIMIT:    sh_ilimit = i_cfg_data[9:0];
                    REG_DEADBAND:  sh_deadband = i_cfg_data[11:0];
                    REG_MIN_SPEED: sh_min_speed = i_cfg_data[7:0];
                    default: ;
                endcase
                cfg_busy = 1'b0;
            end

            // launch the next operation once the gap runs out
            drained = !i_in_valid && (n_sent == n_got);
            if (!in_busy && !cfg_busy) begin
                if (hold_cnt > 0) begin
                    hold_cnt <= hold_cnt - 1;
                end else if (sample_plan.size() > 0) begin
                    op = sample_plan[0];
                    case (op.kind)
                        OP_SAMPLE: begin
                            void'(sample_plan.pop_front());
                            i_accel_angle <= op.accel;
                            i_gyro_rate <= op.gyro;
                            i_elapsed_ms <= op.ms;
                            in_busy = 1'b1;
                            hold_cnt <= calm_in ? 0 : pick_gap();
                            if ($urandom_range(0, 49) == 0) calm_in <= !calm_in;
                        end
                        OP_WRITE: begin
                            if (drained) begin
                                void'(sample_plan.pop_front());
                                i_cfg_index <= op.reg_idx;
                                i_cfg_data <= op.reg_data;
                                cfg_busy = 1'b1;
                                hold_cnt <= calm_in ? 0 : pick_gap();
                            end
                        end
                        default: begin
                            if (drained) void'(sample_plan.pop_front());
                        end
                    endcase
                end
            end
        end
        i_in_valid <= in_busy;
        i_cfg_valid <= cfg_busy;
    end

    // Monitor: check each result item, pace the receiver
    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_got <= n_got + 1;
                if (expected_drive.size() == 0) begin
                    $display("%0t: result item with nothing expected, actual dir %0d speed %0d",
                             $time, o_direction, o_speed);
                    n_errors++;
                end else begin
                    want = expected_drive.pop_front();
                    check_field("direction", longint'(want.direction), longint'(o_direction));
                    check_field("speed", longint'(want.speed), longint'(o_speed));
                    check_field("filtered_angle", longint'($signed(want.angle)),
                                longint'(o_filtered_angle));
                    check_field("pid_output", longint'($signed(want.pid)),
                                longint'(o_pid_output));
                end
            end

            if (stall_cnt > 0) begin
                i_out_ready <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else if (!calm_out && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall_cnt <= pick_gap();
            end else begin
                i_out_ready <= 1'b1;
            end
            if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
                (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Build the plan, release reset, wait for the last result
    initial begin
        int val;
        int sel;
        int center;
        int walk;
        int count;
        int run;
        int ms;
        logic noisy;

        // default registers: deadband, extremes, zero elapsed time
        add_sample(0, 0, 10);
        add_sample(23040, 0, 10);
        add_sample(-23040, 32767, 65535);
        add_sample(32767, 32767, 0);
        add_sample(-32768, -32768, 1);
        add_sample(-32768, -32768, 65535);
        add_sample(0, 0, 0);
        add_sample(300, -300, 10);

        // zero gains, no deadband: a zero sum drives backward
        add_write(REG_KP, 0);
        add_write(REG_KI, 0);
        add_write(REG_KD, 0);
        add_write(REG_ILIMIT, 0);
        add_write(REG_DEADBAND, 0);
        add_write(REG_MIN_SPEED, 255);
        add_write(REG_SETPOINT, 0);
        add_sample(0, 0, 10);
        add_sample(0, 0, 10);
        add_sample(0, 0, 10);
        add_sample(5000, 0, 10);

        // full gains: saturate the sum both ways
        add_write(REG_KP, 65535);
        add_write(REG_KI, 65535);
        add_write(REG_KD, 65535);
        add_write(REG_ILIMIT, 1023);
        add_write(REG_MIN_SPEED, 0);
        add_write(REG_SETPOINT, 32'h7FFF);
        add_write(REG_UNUSED, 32'hFFFF);
        add_sample(-32768, -32768, 1);
        add_sample(32767, 32767, 1);
        add_sample(0, 0, 65535);
        add_sample(-32768, 0, 0);

        // lowest setpoint, widest deadband, upper data bits dropped
        add_write(REG_SETPOINT, 32'h8000);
        add_write(REG_DEADBAND, 32'hFFFF);
        add_write(REG_ILIMIT, 32'hFFFF);
        add_sample(32767, 32767, 1);
        add_sample(0, 0, 10);

        // random phases: new registers, then mostly smooth tilt sequences
        center = 0;
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 7; r++) begin
                sel = $urandom_range(0, 5);
                case (r)
                    REG_SETPOINT: begin
                        val = (sel == 0) ? 32'h8000 : (sel == 1) ? 32'h7FFF :
                              (sel == 2) ? -23040 : (sel == 3) ? 23040 :
                              int'($urandom_range(0, 6000)) - 3000;
                        center = int'($signed(val[15:0]));
                    end
                    REG_KP:
                        val = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 30000);
                    REG_KI, REG_KD:
                        val = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 4000);
                    REG_ILIMIT:
                        val = (sel == 0) ? 0 : (sel == 1) ? 1023 :
                              (sel == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
                    REG_DEADBAND:
                        val = (sel == 0) ? 0 : (sel == 1) ? 4095 :
                              (sel == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
                    default:
                        val = (sel == 0) ? 0 : (sel == 1) ? 255 :
                              (sel == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 80);
                endcase
                add_write(r[CFG_IDX_W-1:0], val);
            end
            if ($urandom_range(0, 2) == 0) add_write(REG_UNUSED, $urandom_range(0, 65535));

            walk = int'(clamp_to(center, -23040, 23040));
            count = 0;
            while (count < 60) begin
                run = $urandom_range(6, 20);
                noisy = ($urandom_range(0, 4) == 0);
                for (int k = 0; k < run; k++) begin
                    if (noisy) begin
                        add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
                    end else begin
                        walk = int'(clamp_to(walk + int'($urandom_range(0, 600)) - 300,
                                             -23040, 23040));
                        sel = $urandom_range(0, 9);
                        ms = (sel < 7) ? $urandom_range(5, 20) : (sel == 7) ? 0 :
                             (sel == 8) ? $urandom_range(1, 4) : $urandom_range(21, 65535);
                        if ($urandom_range(0, 7) == 0)
                            add_sample(walk, int'($urandom_range(0, 8000)) - 4000, ms);
                        else
                            add_sample(walk, int'($urandom_range(0, 600)) - 300, ms);
                    end
                end
                count += run;
                if ($urandom_range(0, 5) == 0) add_settle();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (sample_plan.size() != 0 || i_in_valid || i_cfg_valid || n_sent != n_got);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (expected_drive.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, expected_drive.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
